>>> rtl/urs_pkg.sv
// shared types, constants and the tick-to-centimeter conversion for the ranging block
package urs_pkg;

   localparam int unsigned SENSORS    = 5;
   localparam int unsigned STAMP_BITS = 16;
   localparam int unsigned DIST_BITS  = 10;

   localparam int unsigned THR_BITS    = 10;
   localparam int unsigned PERIOD_BITS = 16;
   localparam int unsigned HOLD_BITS   = 24;
   localparam int unsigned START_BITS  = 2;
   localparam int unsigned DUTY_BITS   = 16;
   localparam int unsigned CSR_BITS    = 24;
   localparam int unsigned PERIODS     = 3;

   localparam int unsigned REQ_BITS = SENSORS;
   localparam int unsigned REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_BITS = SENSORS + 2 + DUTY_BITS + SENSORS * DIST_BITS;
   localparam int unsigned RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // distance = floor(width * 0.343), done as a multiply by 0.343 scaled by 2^CONV_SHIFT and rounded up
   localparam int unsigned CONV_SHIFT = STAMP_BITS + 10;
   localparam int unsigned CONV_BITS  = STAMP_BITS + 9;
   localparam longint unsigned CONV_MULT =
      (64'd343 * (64'd1 << CONV_SHIFT) + 64'd999) / 64'd1000;
   localparam logic [31:0] DIST_MAX = 32'((64'd1 << DIST_BITS) - 64'd1);

   typedef enum logic [2:0] {
      REG_THRESHOLD  = 3'd0,
      REG_FRONT_PER  = 3'd1,
      REG_SIDE_PER_A = 3'd2,
      REG_SIDE_PER_B = 3'd3,
      REG_STOP_HOLD  = 3'd4,
      REG_START_PER  = 3'd5,
      REG_FWD_DUTY   = 3'd6,
      REG_TURN_DUTY  = 3'd7
   } reg_index_type;

   typedef enum logic [5:0] {
      ST_WAIT      = 6'b000001,
      ST_FWD       = 6'b000010,
      ST_HOLD_PRE  = 6'b000100,
      ST_LEFT      = 6'b001000,
      ST_RIGHT     = 6'b010000,
      ST_HOLD_POST = 6'b100000
   } steer_type;

   typedef enum logic [1:0] {
      CMD_STOP    = 2'd0,
      CMD_FORWARD = 2'd1,
      CMD_LEFT    = 2'd2,
      CMD_RIGHT   = 2'd3
   } drive_type;

   typedef enum int unsigned {
      CH_FRONT       = 0,
      CH_FRONT_LEFT  = 1,
      CH_FRONT_RIGHT = 2,
      CH_REAR_LEFT   = 3,
      CH_REAR_RIGHT  = 4
   } channel_type;

   typedef struct packed {
      logic                  accept;
      logic [STAMP_BITS-1:0] stamp;
      logic [STAMP_BITS-1:0] stamp_next;
   } tick_type;

   function automatic logic [DIST_BITS-1:0] cm_of_ticks(input logic [STAMP_BITS-1:0] width);
      logic [STAMP_BITS+CONV_BITS-1:0] prod;
      logic [31:0]                     whole;
      prod  = {{CONV_BITS{1'b0}}, width} *
              {{STAMP_BITS{1'b0}}, CONV_MULT[CONV_BITS-1:0]};
      whole = 32'(prod >> CONV_SHIFT);
      if (whole > DIST_MAX) begin
         cm_of_ticks = DIST_MAX[DIST_BITS-1:0];
      end else begin
         cm_of_ticks = whole[DIST_BITS-1:0];
      end
   endfunction

endpackage

>>> rtl/urs_echo_channel.sv
// one echo channel: edge detection, pulse timing and distance register
module urs_echo_channel
   import urs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tick_type             tick,
   input  logic                 level,
   output logic [DIST_BITS-1:0] dist_now
);

   logic                  prev_ff;
   logic [STAMP_BITS-1:0] start_ff, start_in;
   logic [DIST_BITS-1:0]  dist_ff;
   logic [DIST_BITS-1:0]  cand_ff, cand_in;
   logic                  rise, fall;

   assign rise = level & ~prev_ff;
   assign fall = ~level & prev_ff;

   assign start_in = rise ? tick.stamp : start_ff;
   // cand_ff holds the distance a falling edge on the next tick would give
   assign dist_now = fall ? cand_ff : dist_ff;
   assign cand_in  = cm_of_ticks(tick.stamp_next - start_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         start_ff <= '0;
         dist_ff  <= '0;
         cand_ff  <= '0;
      end else if (tick.accept) begin
         prev_ff  <= level;
         start_ff <= start_in;
         dist_ff  <= dist_now;
         cand_ff  <= cand_in;
      end
   end

endmodule

>>> rtl/ultrasonic_ranging_steering.sv
// top level: trigger scheduling, echo ranging and steering decision per tick
//
// Each req transfer is one 20 us tick carrying the five echo pin levels in
// req_tdata. For every tick exactly one rsp transfer follows, carrying the
// trigger pin levels for that tick, the drive command, the pwm compare value
// and the five latest distances in centimeters (saturated).
// The result of a tick is registered and shows on rsp in the cycle after the
// tick is taken. Throughput is one tick per cycle while rsp is not stalled;
// its loop is the steer state, hold and period counters, updated per tick.
// The result sits in an output register; req_tready stays high while that
// register is empty or being taken, so a stalled receiver holds back at most
// one result and stalls the sender only while that result waits.
// Registers are written through the csr port (enable, index, data); the user
// must write them only while idle, which the block itself does not enforce;
// indexes select threshold, periods, hold time, start wait and two duty values.
// Synchronous reset restores the register defaults, clears all counters,
// distances and echo timing, and puts steering in the waiting state; no
// result is pending after reset.
module ultrasonic_ranging_steering
   import urs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,   // echo_levels
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata,   // trigger_lines, drive_command, pwm_duty,
                                            // dist_front, dist_front_left,
                                            // dist_front_right, dist_rear_left,
                                            // dist_rear_right
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [CSR_BITS-1:0] csr_wdata
);

   logic [THR_BITS-1:0]    thr_ff;
   logic [PERIOD_BITS-1:0] period_ff [PERIODS];
   logic [HOLD_BITS-1:0]   stop_hold_ff;
   logic [START_BITS-1:0]  start_per_ff;
   logic [DUTY_BITS-1:0]   fwd_duty_ff, turn_duty_ff;

   logic [STAMP_BITS-1:0]  stamp_ff;
   logic [PERIOD_BITS-1:0] cnt_ff [PERIODS];
   logic [PERIOD_BITS-1:0] cnt_in [PERIODS];
   logic [PERIODS-1:0]     fire;
   steer_type              steer_ff, steer_in, steer_cur;
   logic [HOLD_BITS-1:0]   hold_ff, hold_in;
   logic [START_BITS-1:0]  start_ff, start_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0]    rsp_data_ff, rsp_data_in;

   logic                   accept;
   tick_type               tick;
   logic [DIST_BITS-1:0]   dist_now [SENSORS];
   logic [SENSORS-1:0]     trig;
   logic                   driving, clear;
   drive_type              cmd;
   logic [DUTY_BITS-1:0]   duty;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);

   assign tick.accept     = accept;
   assign tick.stamp      = stamp_ff;
   assign tick.stamp_next = stamp_ff + 1'b1;

   for (genvar i = 0; i < SENSORS; i++) begin : g_chan
      urs_echo_channel u_chan (
         .clock    (clock),
         .reset    (reset),
         .tick     (tick),
         .level    (req_tdata[i]),
         .dist_now (dist_now[i])
      );
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_BITS'(25);
         period_ff[0] <= PERIOD_BITS'(5000);
         period_ff[1] <= PERIOD_BITS'(6000);
         period_ff[2] <= PERIOD_BITS'(7000);
         stop_hold_ff <= HOLD_BITS'(25000);
         start_per_ff <= START_BITS'(2);
         fwd_duty_ff  <= DUTY_BITS'(12000);
         turn_duty_ff <= DUTY_BITS'(7200);
      end else if (csr_we) begin
         unique case (csr_index)
            REG_THRESHOLD:  thr_ff       <= csr_wdata[THR_BITS-1:0];
            REG_FRONT_PER:  period_ff[0] <= csr_wdata[PERIOD_BITS-1:0];
            REG_SIDE_PER_A: period_ff[1] <= csr_wdata[PERIOD_BITS-1:0];
            REG_SIDE_PER_B: period_ff[2] <= csr_wdata[PERIOD_BITS-1:0];
            REG_STOP_HOLD:  stop_hold_ff <= csr_wdata[HOLD_BITS-1:0];
            REG_START_PER:  start_per_ff <= csr_wdata[START_BITS-1:0];
            REG_FWD_DUTY:   fwd_duty_ff  <= csr_wdata[DUTY_BITS-1:0];
            REG_TURN_DUTY:  turn_duty_ff <= csr_wdata[DUTY_BITS-1:0];
         endcase
      end
   end

   // trigger scheduling
   always_comb begin
      logic [PERIOD_BITS-1:0] nxt;
      for (int k = 0; k < PERIODS; k++) begin
         nxt       = cnt_ff[k] + 1'b1;
         fire[k]   = (nxt >= period_ff[k]);
         cnt_in[k] = fire[k] ? '0 : nxt;
      end
   end

   always_comb begin
      unique case (steer_ff)
         ST_WAIT, ST_FWD, ST_HOLD_PRE, ST_LEFT, ST_RIGHT, ST_HOLD_POST:
            steer_cur = steer_ff;
         default: steer_cur = ST_WAIT;
      endcase
   end

   assign driving = (steer_cur == ST_WAIT) || (steer_cur == ST_FWD);

   always_comb begin
      trig = '0;
      if (fire[0]) begin
         trig[CH_FRONT] = 1'b1;
      end
      // right side yields to front, left side yields to both
      if (fire[2] && !fire[0]) begin
         if (driving) trig[CH_FRONT_RIGHT] = 1'b1;
         else         trig[CH_REAR_RIGHT]  = 1'b1;
      end
      if (fire[1] && !fire[0] && !fire[2]) begin
         if (driving) trig[CH_FRONT_LEFT] = 1'b1;
         else         trig[CH_REAR_LEFT]  = 1'b1;
      end
   end

   assign start_in = (fire[0] && start_ff != '1) ? start_ff + 1'b1 : start_ff;

   assign clear = (dist_now[CH_FRONT] >= thr_ff) && (dist_now[CH_FRONT_LEFT] >= thr_ff) &&
                  (dist_now[CH_FRONT_RIGHT] >= thr_ff);

   // steering
   always_comb begin
      steer_in = steer_cur;
      hold_in  = hold_ff;
      unique case (steer_cur)
         ST_WAIT: begin
            if (start_in >= start_per_ff) begin
               if (clear) begin
                  steer_in = ST_FWD;
               end else begin
                  steer_in = ST_HOLD_PRE;
                  hold_in  = '0;
               end
            end
         end
         ST_FWD: begin
            if (!clear) begin
               steer_in = ST_HOLD_PRE;
               hold_in  = '0;
            end
         end
         ST_HOLD_PRE: begin
            if (hold_ff >= stop_hold_ff) begin
               if (clear) begin
                  steer_in = ST_HOLD_POST;
                  hold_in  = '0;
               end else if (dist_now[CH_REAR_LEFT] > dist_now[CH_REAR_RIGHT]) begin
                  steer_in = ST_LEFT;
               end else begin
                  steer_in = ST_RIGHT;
               end
            end else begin
               hold_in = hold_ff + 1'b1;
            end
         end
         ST_HOLD_POST: begin
            if (hold_ff >= stop_hold_ff) begin
               if (clear) begin
                  steer_in = ST_FWD;
               end else begin
                  steer_in = ST_HOLD_PRE;
                  hold_in  = '0;
               end
            end else begin
               hold_in = hold_ff + 1'b1;
            end
         end
         default: begin
            if (clear) begin
               steer_in = ST_HOLD_POST;
               hold_in  = '0;
            end
         end
      endcase
   end

   always_comb begin
      unique case (steer_in)
         ST_FWD: begin
            cmd  = CMD_FORWARD;
            duty = fwd_duty_ff;
         end
         ST_LEFT: begin
            cmd  = CMD_LEFT;
            duty = turn_duty_ff;
         end
         ST_RIGHT: begin
            cmd  = CMD_RIGHT;
            duty = turn_duty_ff;
         end
         default: begin
            cmd  = CMD_STOP;
            duty = '0;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = {dist_now[CH_REAR_RIGHT], dist_now[CH_REAR_LEFT],
                     dist_now[CH_FRONT_RIGHT], dist_now[CH_FRONT_LEFT],
                     dist_now[CH_FRONT], duty, cmd, trig};
   end

   assign rsp_valid_in = accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         stamp_ff     <= '0;
         for (int k = 0; k < PERIODS; k++) cnt_ff[k] <= '0;
         steer_ff     <= ST_WAIT;
         hold_ff      <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            stamp_ff <= tick.stamp_next;
            for (int k = 0; k < PERIODS; k++) cnt_ff[k] <= cnt_in[k];
            steer_ff <= steer_in;
            hold_ff  <= hold_in;
            start_ff <= start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // at most one trigger pulse per tick
   a_one_trigger: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(rsp_data_ff[SENSORS-1:0]))
      else $error("more than one trigger in a tick");

   // stopped means no pwm drive
   a_stop_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[SENSORS+1:SENSORS] == CMD_STOP) |->
      rsp_data_ff[SENSORS+2+DUTY_BITS-1:SENSORS+2] == '0)
      else $error("nonzero duty while stopped");

   // every accepted tick leaves a result pending
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick produced no result");

   // steering never leaves waiting before the start count is met
   a_start_wait: assert property (@(posedge clock) disable iff (reset)
      (accept && steer_ff == ST_WAIT && start_in < start_per_ff) |=> steer_ff == ST_WAIT)
      else $error("steering left waiting early");

endmodule

>>> sim/urs_checker.sv
// checker for the ranging block: predicts every tick report and compares it with rsp
module urs_checker
   import urs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [REQ_W-1:0]    req_tdata,   // echo_levels
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RSP_W-1:0]    rsp_tdata,   // trigger_lines, drive_command, pwm_duty,
                                            // dist_front .. dist_rear_right
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [CSR_BITS-1:0] csr_wdata,
   output int unsigned         reports_pending,
   output int unsigned         mismatch_count
);

   localparam int P_FRONT  = 0;
   localparam int P_SIDE_A = 1;
   localparam int P_SIDE_B = 2;

   // same layout as rsp_tdata, lowest field last
   typedef struct packed {
      logic [SENSORS-1:0][DIST_BITS-1:0] dist_cm;
      logic [DUTY_BITS-1:0]              duty;
      drive_type                         command;
      logic [SENSORS-1:0]                trigger;
   } tick_report_t;

   // register copy
   logic [THR_BITS-1:0]    threshold_cm;
   logic [PERIOD_BITS-1:0] period_len [PERIODS];
   logic [HOLD_BITS-1:0]   hold_len;
   logic [START_BITS-1:0]  start_need;
   logic [DUTY_BITS-1:0]   forward_duty;
   logic [DUTY_BITS-1:0]   turn_duty;

   // predicted block state
   logic [STAMP_BITS-1:0]  stamp;
   logic [PERIOD_BITS-1:0] period_cnt [PERIODS];
   logic [SENSORS-1:0]     echo_was;
   logic [STAMP_BITS-1:0]  rise_stamp [SENSORS];
   logic [DIST_BITS-1:0]   range_cm [SENSORS];
   steer_type              steer;
   logic [HOLD_BITS-1:0]   hold_cnt;
   logic [1:0]             front_pulses;

   tick_report_t awaited [$];
   int unsigned  errors = 0;

   function automatic logic path_clear();
      return range_cm[CH_FRONT] >= threshold_cm && range_cm[CH_FRONT_LEFT] >= threshold_cm &&
             range_cm[CH_FRONT_RIGHT] >= threshold_cm;
   endfunction

   task automatic stop_for(input steer_type stop_state);
      steer    = stop_state;
      hold_cnt = '0;
   endtask

   task automatic compute_tick_report(input logic [SENSORS-1:0] echoes,
                                      output tick_report_t rep);
      logic [STAMP_BITS-1:0]  width;
      int unsigned            cm;
      logic [PERIOD_BITS-1:0] next_cnt;
      logic [PERIODS-1:0]     fire;
      logic                   driving;
      int                     i;
      rep = '0;
      // echo edges use the stamp before it advances
      for (i = 0; i < SENSORS; i++) begin
         if (echoes[i] && !echo_was[i]) begin
            rise_stamp[i] = stamp;
         end else if (!echoes[i] && echo_was[i]) begin
            width = stamp - rise_stamp[i];
            cm = (32'(width) * 343) / 1000;
            range_cm[i] = (cm > DIST_MAX) ? DIST_MAX[DIST_BITS-1:0] : DIST_BITS'(cm);
         end
      end
      echo_was = echoes;
      stamp    = stamp + 1'b1;

      driving = (steer == ST_WAIT) || (steer == ST_FWD);
      for (i = 0; i < PERIODS; i++) begin
         next_cnt      = period_cnt[i] + 1'b1;
         fire[i]       = next_cnt >= period_len[i];
         period_cnt[i] = fire[i] ? '0 : next_cnt;
      end
      // front wins over the right side, which wins over the left side
      if (fire[P_FRONT]) begin
         rep.trigger[CH_FRONT] = 1'b1;
         if (front_pulses != 2'd3) begin
            front_pulses = front_pulses + 1'b1;
         end
      end else if (fire[P_SIDE_B]) begin
         rep.trigger[driving ? CH_FRONT_RIGHT : CH_REAR_RIGHT] = 1'b1;
      end else if (fire[P_SIDE_A]) begin
         rep.trigger[driving ? CH_FRONT_LEFT : CH_REAR_LEFT] = 1'b1;
      end

      case (steer)
         ST_FWD: begin
            if (!path_clear()) begin
               stop_for(ST_HOLD_PRE);
            end
         end
         ST_HOLD_PRE, ST_HOLD_POST: begin
            if (hold_cnt >= hold_len) begin
               if (steer == ST_HOLD_PRE) begin
                  if (path_clear()) begin
                     stop_for(ST_HOLD_POST);
                  end else begin
                     steer = (range_cm[CH_REAR_LEFT] > range_cm[CH_REAR_RIGHT]) ? ST_LEFT
                                                                                : ST_RIGHT;
                  end
               end else if (path_clear()) begin
                  steer = ST_FWD;
               end else begin
                  stop_for(ST_HOLD_PRE);
               end
            end else begin
               hold_cnt = hold_cnt + 1'b1;
            end
         end
         ST_LEFT, ST_RIGHT: begin
            if (path_clear()) begin
               stop_for(ST_HOLD_POST);
            end
         end
         default: begin
            if (front_pulses >= start_need) begin
               if (path_clear()) begin
                  steer = ST_FWD;
               end else begin
                  stop_for(ST_HOLD_PRE);
               end
            end
         end
      endcase

      case (steer)
         ST_FWD: begin
            rep.command = CMD_FORWARD;
            rep.duty    = forward_duty;
         end
         ST_LEFT: begin
            rep.command = CMD_LEFT;
            rep.duty    = turn_duty;
         end
         ST_RIGHT: begin
            rep.command = CMD_RIGHT;
            rep.duty    = turn_duty;
         end
         default: begin
            rep.command = CMD_STOP;
            rep.duty    = '0;
         end
      endcase
      for (i = 0; i < SENSORS; i++) begin
         rep.dist_cm[i] = range_cm[i];
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      tick_report_t want_rep;
      tick_report_t got_rep;
      int           i;
      if (reset) begin
         threshold_cm           = 10'd25;
         period_len[P_FRONT]    = 16'd5000;
         period_len[P_SIDE_A]   = 16'd6000;
         period_len[P_SIDE_B]   = 16'd7000;
         hold_len               = 24'd25000;
         start_need             = 2'd2;
         forward_duty           = 16'd12000;
         turn_duty              = 16'd7200;
         stamp                  = '0;
         echo_was               = '0;
         steer                  = ST_WAIT;
         hold_cnt               = '0;
         front_pulses           = '0;
         for (i = 0; i < PERIODS; i++) begin
            period_cnt[i] = '0;
         end
         for (i = 0; i < SENSORS; i++) begin
            rise_stamp[i] = '0;
            range_cm[i]   = '0;
         end
         awaited.delete();
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_THRESHOLD:  threshold_cm         = csr_wdata[THR_BITS-1:0];
               REG_FRONT_PER:  period_len[P_FRONT]  = csr_wdata[PERIOD_BITS-1:0];
               REG_SIDE_PER_A: period_len[P_SIDE_A] = csr_wdata[PERIOD_BITS-1:0];
               REG_SIDE_PER_B: period_len[P_SIDE_B] = csr_wdata[PERIOD_BITS-1:0];
               REG_STOP_HOLD:  hold_len             = csr_wdata[HOLD_BITS-1:0];
               REG_START_PER:  start_need           = csr_wdata[START_BITS-1:0];
               REG_FWD_DUTY:   forward_duty         = csr_wdata[DUTY_BITS-1:0];
               default:        turn_duty            = csr_wdata[DUTY_BITS-1:0];
            endcase
         end
         // a report leaving now belongs to an earlier tick, so pop before push
         if (rsp_tvalid && rsp_tready) begin
            got_rep = tick_report_t'(rsp_tdata[RSP_BITS-1:0]);
            if (awaited.size() == 0) begin
               errors++;
               $display("%0t: report with no tick waiting, expected none got %h",
                        $time, rsp_tdata);
            end else begin
               want_rep = awaited.pop_front();
               compare_field("trigger_lines", want_rep.trigger, got_rep.trigger);
               compare_field("drive_command", want_rep.command, got_rep.command);
               compare_field("pwm_duty", want_rep.duty, got_rep.duty);
               for (i = 0; i < SENSORS; i++) begin
                  compare_field($sformatf("distance ch%0d", i), want_rep.dist_cm[i],
                                got_rep.dist_cm[i]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            compute_tick_report(req_tdata[SENSORS-1:0], want_rep);
            awaited.push_back(want_rep);
         end
      end
      reports_pending <= awaited.size();
      mismatch_count  <= errors;
   end

endmodule

>>> sim/tb_ultrasonic_ranging_steering.sv
// testbench top: drives echo ticks and register writes into the ranging block, gives the verdict
module tb_ultrasonic_ranging_steering;
   import urs_pkg::*;

   // slowest run is about a thousand ticks
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_TICKS  = 200;   // one long echo on every channel

   localparam logic [SENSORS-1:0] DIRECTED_ECHOES [24] = '{
      5'b00000, 5'b11111, 5'b00000, 5'b00001, 5'b00010, 5'b00100, 5'b01000, 5'b10000,
      5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b00000, 5'b11000, 5'b11000, 5'b01000,
      5'b00000, 5'b10101, 5'b01010, 5'b10101, 5'b00111, 5'b00111, 5'b00000, 5'b11111
   };

   typedef enum {PACE_FREE, PACE_SENDER_SLOW, PACE_RECEIVER_SLOW, PACE_BOTH_SLOW} pace_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata  = '0;   // echo_levels
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;         // trigger_lines, drive_command, pwm_duty,
                                           // dist_front, dist_front_left, dist_front_right,
                                           // dist_rear_left, dist_rear_right
   logic                csr_we     = 1'b0;
   logic [2:0]          csr_index  = '0;
   logic [CSR_BITS-1:0] csr_wdata  = '0;

   int unsigned         reports_pending;
   int unsigned         mismatch_count;
   int unsigned         cycles = 0;
   pace_type            pace = PACE_FREE;
   logic [SENSORS-1:0]  echo_level = '0;
   int unsigned         echo_left [SENSORS] = '{default: 0};

   ultrasonic_ranging_steering DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata
   );

   urs_checker report_check (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_we, .csr_index, .csr_wdata,
      .reports_pending, .mismatch_count
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      case (pace)
         PACE_RECEIVER_SLOW: rsp_tready <= $urandom_range(99) >= 75;
         PACE_BOTH_SLOW:     rsp_tready <= $urandom_range(99) >= 18;
         default:            rsp_tready <= 1'b1;
      endcase
   end

   function automatic logic sender_rests();
      case (pace)
         PACE_SENDER_SLOW: return $urandom_range(99) < 75;
         PACE_BOTH_SLOW:   return $urandom_range(99) < 18;
         default:          return 1'b0;
      endcase
   endfunction

   // each channel alternates echo pulses and gaps of random length, with some noise ticks
   function automatic logic [SENSORS-1:0] next_echoes(input int unsigned high_max);
      int i;
      for (i = 0; i < SENSORS; i++) begin
         if (echo_left[i] == 0) begin
            echo_level[i] = ~echo_level[i];
            echo_left[i]  = echo_level[i] ? $urandom_range(high_max, 1) : $urandom_range(12, 1);
         end
         echo_left[i]--;
      end
      if ($urandom_range(9) == 0) begin
         return SENSORS'($urandom);
      end
      return echo_level;
   endfunction

   task automatic send_tick(input logic [SENSORS-1:0] echoes);
      while (sender_rests()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(echoes);
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   // sender holds off until every tick report has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [CSR_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [CSR_BITS-1:0] thr, front_per, side_a, side_b,
                                input logic [CSR_BITS-1:0] hold, start, fwd_duty, turn_duty);
      drain();
      write_csr(REG_THRESHOLD, thr);
      write_csr(REG_FRONT_PER, front_per);
      write_csr(REG_SIDE_PER_A, side_a);
      write_csr(REG_SIDE_PER_B, side_b);
      write_csr(REG_STOP_HOLD, hold);
      write_csr(REG_START_PER, start);
      write_csr(REG_FWD_DUTY, fwd_duty);
      write_csr(REG_TURN_DUTY, turn_duty);
      csr_we <= 1'b0;
   endtask

   task automatic run_ticks(input pace_type p, input int unsigned count,
                            input int unsigned high_max);
      pace <= p;
      repeat (count) send_tick(next_echoes(high_max));
   endtask

   initial begin
      int unsigned k;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: coincident pulses, immediate start, no hold, extreme duties
      load_settings(24'd3, 24'd4, 24'd2, 24'd3, 24'd0, 24'd0, 24'hFFFF, 24'd0);
      for (k = 0; k < $size(DIRECTED_ECHOES); k++) begin
         send_tick(DIRECTED_ECHOES[k]);
      end

      load_settings(24'd5, 24'd7, 24'd11, 24'd13, 24'd3, 24'd1,
                    CSR_BITS'($urandom), CSR_BITS'($urandom));
      run_ticks(PACE_FREE, 100, 40);

      // zero threshold keeps the path clear
      load_settings(24'd0, 24'd2, 24'd2, 24'd2, 24'd0, 24'd3,
                    CSR_BITS'($urandom), CSR_BITS'($urandom));
      run_ticks(PACE_SENDER_SLOW, 80, 30);

      load_settings(24'd8, 24'd5, 24'd3, 24'd4, 24'd10, 24'd2,
                    CSR_BITS'($urandom), CSR_BITS'($urandom));
      run_ticks(PACE_RECEIVER_SLOW, 100, 60);

      // longest periods and an endless stop
      load_settings(24'd4, 24'hFFFF, 24'hFFFF, 24'hFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'hFFFF);
      run_ticks(PACE_BOTH_SLOW, 80, 30);

      load_settings(24'd6, 24'd9, 24'd6, 24'd10, 24'd1, 24'd2,
                    CSR_BITS'($urandom), CSR_BITS'($urandom));
      run_ticks(PACE_BOTH_SLOW, 100, 50);

      // long echoes against the top threshold, upper data bits are dropped
      load_settings(24'hABC3FF, 24'd3, 24'd5, 24'd7, 24'd2, 24'd1,
                    CSR_BITS'($urandom), CSR_BITS'($urandom));
      pace <= PACE_FREE;
      repeat (LONG_TICKS) send_tick('1);
      repeat (20) send_tick('0);
      run_ticks(PACE_BOTH_SLOW, 40, 8);

      // periods below the legal range fire every tick
      load_settings(24'h5F5402, 24'd0, 24'd1, 24'd0, 24'd5, 24'hFFFFFF,
                    CSR_BITS'($urandom), CSR_BITS'($urandom));
      run_ticks(PACE_SENDER_SLOW, 80, 20);

      for (k = 0; k < 3; k++) begin
         load_settings(CSR_BITS'($urandom_range(15)), CSR_BITS'($urandom_range(20, 2)),
                       CSR_BITS'($urandom_range(20, 2)), CSR_BITS'($urandom_range(20, 2)),
                       CSR_BITS'($urandom_range(8)), CSR_BITS'($urandom_range(3)),
                       CSR_BITS'($urandom), CSR_BITS'($urandom));
         run_ticks(pace_type'(k + 1), 40, 45);
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
